FILE: rtl/beswb_pkg.sv
// Package for the body Euler step with wall bounce block.
// Holds the Q16.16 constants, stage payload type and fixed-point helpers.
// Depends on nothing; used by body_euler_step_with_wall_bounce.
package beswb_pkg;

  localparam int unsigned StageN   = 8;
  localparam int unsigned InW      = 368;
  localparam int unsigned OutW     = 288;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgAreaWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAreaHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWorldScale = 2'd2;

  localparam logic [15:0]        AreaWidthRst  = 16'd640;
  localparam logic [15:0]        AreaHeightRst = 16'd480;
  localparam logic [23:0]        WorldScaleRst = 24'd65536;

  localparam logic [10:0]        DtMaxQ  = 11'd1049;
  localparam logic signed [11:0] DampQ   = -12'sd655;
  localparam logic [19:0]        GravQ   = 20'd642908;
  localparam logic signed [31:0] VelLimQ = 32'sd65536000;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] frc;
    logic [2:0][31:0] aux;
    logic [2:0][31:0] vdt;
    logic [2:0][31:0] hdt;
    logic [31:0]      g;
    logic [30:0]      mass;
    logic [30:0]      inv;
    logic [10:0]      dt;
  } stage_t;

  typedef struct packed {
    logic [31:0] p;
    logic        flip;
  } wall_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] mul64(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic signed [63:0] add64(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return 64'(a) + 64'(b);
  endfunction

  // Rounds half up, which is a floor after adding half an LSB.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] rnd17(input logic signed [63:0] p);
    return (p + 64'sd65536) >>> 17;
  endfunction

  function automatic logic [31:0] vclamp(input logic signed [31:0] v);
    if (v > VelLimQ) begin
      return VelLimQ;
    end else if (v < -VelLimQ) begin
      return -VelLimQ;
    end
    return v;
  endfunction

  function automatic wall_t bounce(input logic signed [31:0] p, input logic [15:0] w);
    logic signed [63:0] hi;
    logic signed [63:0] pe;
    wall_t r;
    hi = $signed({32'd0, w, 16'd0});
    pe = 64'(p);
    r.p    = p;
    r.flip = 1'b0;
    if (pe < 64'sd0) begin
      r.p    = sat32(-pe);
      r.flip = 1'b1;
    end else if (pe > hi) begin
      r.p    = sat32((hi <<< 1) - pe);
      r.flip = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/body_euler_step_with_wall_bounce.sv
// Top level of the body Euler step with wall bounce block.
// Eight-stage pipeline of damping, integration, gravity and wall reflection.
// Depends on beswb_pkg.

// One body request enters per clock when the output side keeps up, and its
// result leaves through the eight register stages of the integration
// pipeline; each stage holds at most one multiply or one add with
// saturation. Every stage has its own valid bit and advances whenever
// the stage after it is empty or moving, so a stalled output only freezes the
// requests behind it while empty stages keep filling. Configuration is taken
// at any time and must only change while the pipeline is empty.
module body_euler_step_with_wall_bounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [beswb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [beswb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, frc_x, frc_y, frc_z,
  // body_mass, body_inv_mass, time_step, zero padding
  input  logic [beswb_pkg::InW-1:0]      s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // new_frc_x, new_frc_y, new_frc_z
  output logic [beswb_pkg::OutW-1:0]     m_axis_tdata_o
);
  import beswb_pkg::*;

  logic [15:0]   width_q;
  logic [15:0]   height_q;
  logic [23:0]   scale_q;
  logic [StageN:1] v_q;
  logic [StageN:1] en;
  stage_t        st_q [1:StageN];
  stage_t        st_d [1:StageN];
  logic [15:0]   dt_raw;
  logic [10:0]   dt_c;
  wall_t         wx;
  wall_t         wy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= AreaWidthRst;
      height_q <= AreaHeightRst;
      scale_q  <= WorldScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAreaWidth:  width_q  <= cfg_data_i[15:0];
        CfgAreaHeight: height_q <= cfg_data_i[15:0];
        CfgWorldScale: scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[StageN] = !v_q[StageN] || m_axis_tready_i;
    for (int k = StageN - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = v_q[StageN];

  assign dt_raw = s_axis_tdata_i[365:350];
  assign dt_c   = (dt_raw > 16'(DtMaxQ)) ? DtMaxQ : dt_raw[10:0];

  always_comb begin
    st_d[1]      = '0;
    st_d[1].mass = s_axis_tdata_i[318:288];
    st_d[1].inv  = s_axis_tdata_i[349:319];
    st_d[1].dt   = dt_c;
    st_d[1].g    = sat32(rnd16(mul64(32'(GravQ), 32'(scale_q))));
    for (int i = 0; i < 3; i++) begin
      st_d[1].pos[i] = s_axis_tdata_i[32*i +: 32];
      st_d[1].vel[i] = s_axis_tdata_i[96 + 32*i +: 32];
      st_d[1].frc[i] = s_axis_tdata_i[192 + 32*i +: 32];
      st_d[1].aux[i] = sat32(rnd16(mul64(s_axis_tdata_i[96 + 32*i +: 32], 32'(DampQ))));
      st_d[1].vdt[i] = sat32(rnd16(mul64(s_axis_tdata_i[96 + 32*i +: 32], 32'(dt_c))));
    end

    st_d[2]   = st_q[1];
    st_d[2].g = sat32(rnd16(mul64(st_q[1].g, 32'(st_q[1].mass))));
    for (int i = 0; i < 3; i++) begin
      st_d[2].frc[i] = sat32(add64(st_q[1].frc[i], st_q[1].aux[i]));
    end

    st_d[3]   = st_q[2];
    st_d[3].g = sat32(rnd16(mul64(st_q[2].g, 32'(st_q[2].dt))));
    for (int i = 0; i < 3; i++) begin
      st_d[3].aux[i] = sat32(rnd16(mul64(st_q[2].frc[i], 32'(st_q[2].inv))));
    end

    st_d[4]        = st_q[3];
    st_d[4].frc[1] = sat32(add64(st_q[3].frc[1], st_q[3].g));
    for (int i = 0; i < 3; i++) begin
      st_d[4].aux[i] = sat32(rnd16(mul64(st_q[3].aux[i], 32'(st_q[3].dt))));
    end

    st_d[5] = st_q[4];
    for (int i = 0; i < 3; i++) begin
      st_d[5].hdt[i] = sat32(rnd17(mul64(st_q[4].aux[i], 32'(st_q[4].dt))));
      st_d[5].vel[i] = vclamp(sat32(add64(st_q[4].vel[i], st_q[4].aux[i])));
    end

    st_d[6] = st_q[5];
    for (int i = 0; i < 3; i++) begin
      st_d[6].vdt[i] = sat32(add64(st_q[5].vdt[i], st_q[5].hdt[i]));
    end

    st_d[7] = st_q[6];
    for (int i = 0; i < 3; i++) begin
      st_d[7].pos[i] = sat32(add64(st_q[6].pos[i], st_q[6].vdt[i]));
    end

    wx             = bounce(st_q[7].pos[0], width_q);
    wy             = bounce(st_q[7].pos[1], height_q);
    st_d[8]        = st_q[7];
    st_d[8].pos[0] = wx.p;
    st_d[8].pos[1] = wy.p;
    st_d[8].vel[0] = wx.flip ? -st_q[7].vel[0] : st_q[7].vel[0];
    st_d[8].vel[1] = wy.flip ? -st_q[7].vel[1] : st_q[7].vel[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= StageN; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1] && s_axis_tvalid_i) begin
      st_q[1] <= st_d[1];
    end
    for (int k = 2; k <= StageN; k++) begin
      if (en[k] && v_q[k-1]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata_o[32*i +: 32]       = st_q[StageN].pos[i];
      m_axis_tdata_o[96 + 32*i +: 32]  = st_q[StageN].vel[i];
      m_axis_tdata_o[192 + 32*i +: 32] = st_q[StageN].frc[i];
    end
  end

  a_vel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(st_q[StageN].vel[0]) <= VelLimQ && $signed(st_q[StageN].vel[0]) >= -VelLimQ &&
       $signed(st_q[StageN].vel[1]) <= VelLimQ && $signed(st_q[StageN].vel[1]) >= -VelLimQ &&
       $signed(st_q[StageN].vel[2]) <= VelLimQ && $signed(st_q[StageN].vel[2]) >= -VelLimQ))
    else $error("velocity leaves the clamp range");

  a_grav_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> !st_q[4].g[31])
    else $error("gravity term turned negative");

  a_dt_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> st_q[1].dt <= DtMaxQ)
    else $error("time step above its clamp");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q && !m_axis_tready_i))
    else $error("input stalled while the pipeline has room");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[StageN-1] && !en[StageN-1]) |=> v_q[StageN-1] && $stable(st_q[StageN-1]))
    else $error("stalled stage lost its request");

endmodule

FILE: dv/body_step_checker.sv
// Checker for the body Euler step with wall bounce block.
// Predicts each result from the accepted requests and compares it with the output.
// Depends on beswb_pkg for the port widths and register indexes.
module body_step_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [beswb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [beswb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, frc_x, frc_y, frc_z,
  // body_mass, body_inv_mass, time_step, zero padding
  input  logic [beswb_pkg::InW-1:0]      in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // new_frc_x, new_frc_y, new_frc_z
  input  logic [beswb_pkg::OutW-1:0]     out_data_i,
  output int                             err_count_o,
  output int                             pending_o
);

  localparam longint DtCapQ    = 1049;
  localparam longint DampQ     = 655;
  localparam longint GravQ     = 642908;
  localparam longint VelCapQ   = 65536000;
  localparam longint UnitQ     = 65536;
  localparam longint MaxS32    = 64'sd2147483647;
  localparam longint MinS32    = -64'sd2147483648;

  logic [15:0] wall_w;
  logic [15:0] wall_h;
  logic [23:0] grav_scale;
  logic [beswb_pkg::OutW-1:0] expected_bodies[$];
  logic [beswb_pkg::OutW-1:0] oldest;
  string field_names[9] = '{"new_pos_x", "new_pos_y", "new_pos_z",
                            "new_vel_x", "new_vel_y", "new_vel_z",
                            "new_frc_x", "new_frc_y", "new_frc_z"};

  function automatic longint clip32(input longint v);
    if (v > MaxS32) begin
      return MaxS32;
    end else if (v < MinS32) begin
      return MinS32;
    end
    return v;
  endfunction

  // Exact product, then a floor shift after adding half an LSB.
  function automatic longint q_mul(input longint a, input longint b, input int sh);
    longint prod;
    prod = a * b + (longint'(1) <<< (sh - 1));
    return prod >>> sh;
  endfunction

  function automatic longint mirror(input longint p, input longint lim, output bit hit);
    hit = 1'b1;
    if (p < 0) begin
      return clip32(-p);
    end else if (p > lim) begin
      return clip32(2 * lim - p);
    end
    hit = 1'b0;
    return p;
  endfunction

  function automatic logic [beswb_pkg::OutW-1:0] euler_bounce_step(
    input logic [beswb_pkg::InW-1:0] req
  );
    longint p[3];
    longint v[3];
    longint f[3];
    longint mass;
    longint inv;
    longint dt;
    longint acc;
    longint dv;
    longint dp;
    longint g;
    bit hit;
    logic [beswb_pkg::OutW-1:0] res;
    mass = longint'(req[318:288]);
    inv  = longint'(req[349:319]);
    dt   = longint'(req[365:350]);
    if (dt > DtCapQ) begin
      dt = DtCapQ;
    end
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(req[32*i +: 32]));
      v[i] = longint'($signed(req[32*(3+i) +: 32]));
      f[i] = longint'($signed(req[32*(6+i) +: 32]));
      f[i] = clip32(f[i] + clip32(q_mul(v[i], -DampQ, 16)));
      acc  = clip32(q_mul(f[i], inv, 16));
      dv   = clip32(q_mul(acc, dt, 16));
      dp   = clip32(q_mul(v[i], dt, 16) + q_mul(dv, dt, 17));
      p[i] = clip32(p[i] + dp);
      v[i] = clip32(v[i] + dv);
    end
    g = clip32(q_mul(GravQ, longint'(grav_scale), 16));
    g = clip32(q_mul(g, mass, 16));
    g = clip32(q_mul(g, dt, 16));
    f[1] = clip32(f[1] + g);
    for (int i = 0; i < 3; i++) begin
      if (v[i] > VelCapQ) begin
        v[i] = VelCapQ;
      end else if (v[i] < -VelCapQ) begin
        v[i] = -VelCapQ;
      end
    end
    p[0] = mirror(p[0], longint'(wall_w) * UnitQ, hit);
    if (hit) begin
      v[0] = -v[0];
    end
    p[1] = mirror(p[1], longint'(wall_h) * UnitQ, hit);
    if (hit) begin
      v[1] = -v[1];
    end
    for (int i = 0; i < 3; i++) begin
      res[32*i +: 32]     = p[i][31:0];
      res[32*(3+i) +: 32] = v[i][31:0];
      res[32*(6+i) +: 32] = f[i][31:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_w      <= 16'd640;
      wall_h      <= 16'd480;
      grav_scale  <= 24'd65536;
      expected_bodies.delete();
      err_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          beswb_pkg::CfgAreaWidth: begin
            wall_w <= cfg_data_i[15:0];
          end
          beswb_pkg::CfgAreaHeight: begin
            wall_h <= cfg_data_i[15:0];
          end
          beswb_pkg::CfgWorldScale: begin
            grav_scale <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_bodies.push_back(euler_bounce_step(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_bodies.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_data_i);
          err_count_o = err_count_o + 1;
        end else begin
          oldest = expected_bodies.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (oldest[32*k +: 32] !== out_data_i[32*k +: 32]) begin
              $display("%0t: %s mismatch, expected %h, actual %h", $time, field_names[k],
                       oldest[32*k +: 32], out_data_i[32*k +: 32]);
              err_count_o = err_count_o + 1;
            end
          end
        end
      end
      pending_o <= expected_bodies.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Top of the testbench for body_euler_step_with_wall_bounce.
// Drives directed and random body requests, configuration phases and output stalls.
// Depends on beswb_pkg, the block and body_step_checker.
module tb_top;

  localparam int One           = 65536;
  localparam int DirectedItems = 22;
  localparam int Phases        = 8;
  localparam int PhaseItems    = 204;
  localparam int HoldPhase     = 5;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 24;
  localparam int WatchdogLimit = 4000;
  localparam logic [beswb_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [beswb_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [beswb_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                           s_valid = 1'b0;
  logic                           s_ready;
  logic [beswb_pkg::InW-1:0]      s_data = '0;
  logic                           m_valid;
  logic                           m_ready = 1'b0;
  logic [beswb_pkg::OutW-1:0]     m_data;
  int                             err_count;
  int                             pending;
  int                             idle_cycles = 0;
  bit                             src_gaps = 1'b1;
  bit                             sink_gaps = 1'b1;
  bit                             hold_sink = 1'b0;
  int unsigned                    cur_w = 640;
  int unsigned                    cur_h = 480;

  always #2 clk = ~clk;

  body_euler_step_with_wall_bounce u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  body_step_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (s_valid),
    .in_ready_i  (s_ready),
    .in_data_i   (s_data),
    .out_valid_i (m_valid),
    .out_ready_i (m_ready),
    .out_data_i  (m_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  function automatic logic [beswb_pkg::InW-1:0] pack_body(
    input logic [31:0] px, py, pz, vx, vy, vz, fx, fy, fz,
    input logic [30:0] mass, inv,
    input logic [15:0] dt
  );
    return {2'b00, dt, inv, mass, fz, fy, fx, vz, vy, vx, pz, py, px};
  endfunction

  function automatic logic [beswb_pkg::InW-1:0] directed_body(input int k);
    logic [31:0] p[3];
    logic [31:0] v[3];
    logic [31:0] f[3];
    logic [30:0] mass;
    logic [30:0] inv;
    logic [15:0] dt;
    p    = '{100 * One, 100 * One, 0};
    v    = '{0, 0, 0};
    f    = '{0, 0, 0};
    mass = 31'(One);
    inv  = 31'(One);
    dt   = 16'd1049;
    case (k)
      0: begin
        p = '{0, 0, 0};
        mass = '0;
        inv = '0;
        dt = '0;
      end
      1: begin
        p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        v = p;
        f = p;
        mass = 31'h7FFF_FFFF;
        inv = 31'h7FFF_FFFF;
        dt = 16'hFFFF;
      end
      2: begin
        p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        v = p;
        f = p;
        mass = '0;
        inv = '0;
        dt = '0;
      end
      3: ;
      4: begin
        dt = 16'd1050;
        v = '{3 * One, -2 * One, One};
      end
      5: begin
        dt = 16'd1048;
        f = '{5 * One, -5 * One, 7 * One};
      end
      6: begin
        p[0] = -100;
        v[0] = -One;
      end
      7: p[0] = 32'h8000_0000;
      8: begin
        p[0] = 640 * One + 100;
        v[0] = 2 * One;
      end
      9: begin
        p[0] = 32'h7FFF_FFFF;
        v[0] = 500 * One;
      end
      10: begin
        p[1] = -5;
        v[1] = -3 * One;
      end
      11: begin
        p[1] = 480 * One + 50;
        v[1] = One;
      end
      12: v[0] = 2000 * One;
      13: v[1] = -(2000 * One);
      14: begin
        p[2] = -5 * One;
        v[2] = -One;
      end
      15: begin
        mass = 31'h7FFF_FFFF;
        inv = '0;
        f[1] = 32'h7FFF_FFFF;
        dt = 16'hFFFF;
      end
      16: begin
        f = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        inv = 31'h7FFF_FFFF;
      end
      17: v = '{1000 * One, -(1000 * One), 1000 * One};
      18: p = '{0, 480 * One, 640 * One};
      19: begin
        p = '{1, 1, 1};
        v = '{-1, -1, -1};
        f = '{-1, -1, -1};
      end
      20: begin
        v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        inv = 31'd1;
      end
      default: begin
        p[0] = 640 * One;
        mass = 31'd1;
        inv = 31'd1;
        dt = 16'd1;
      end
    endcase
    return pack_body(p[0], p[1], p[2], v[0], v[1], v[2], f[0], f[1], f[2], mass, inv, dt);
  endfunction

  // Positions cluster around the walls so that reflections are frequent.
  function automatic logic [beswb_pkg::InW-1:0] random_body();
    logic [31:0] p[3];
    logic [31:0] v[3];
    logic [31:0] f[3];
    logic [30:0] mass;
    logic [30:0] inv;
    logic [15:0] dt;
    longint lim;
    longint t;
    if ($urandom_range(0, 4) == 0) begin
      return pack_body($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom(),
                       31'($urandom()), 31'($urandom()), 16'($urandom()));
    end
    for (int i = 0; i < 3; i++) begin
      v[i] = $urandom_range(0, 2400 * One) - 1200 * One;
      f[i] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    end
    for (int i = 0; i < 2; i++) begin
      lim = longint'((i == 0) ? cur_w : cur_h) * One;
      case ($urandom_range(0, 3))
        0: t = longint'($urandom_range(0, 4000)) - 2000;
        1: t = lim + longint'($urandom_range(0, 4000)) - 2000;
        default: t = longint'($urandom()) % (lim + 3 * One) - One;
      endcase
      if (t > 64'sd2147483647) begin
        t = 64'sd2147483647;
      end
      p[i] = t[31:0];
    end
    p[2] = $urandom();
    mass = 31'($urandom_range(0, 200 * One));
    inv  = 31'($urandom_range(0, 8 * One));
    dt   = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1100));
    return pack_body(p[0], p[1], p[2], v[0], v[1], v[2], f[0], f[1], f[2], mass, inv, dt);
  endfunction

  task automatic push_body(input logic [beswb_pkg::InW-1:0] req);
    int gap;
    gap = src_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= req;
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic write_reg(input logic [beswb_pkg::CfgIdxW-1:0] idx,
                           input logic [beswb_pkg::CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // The pipeline is drained before the walls or the gravity scale change.
  task automatic configure(input int ph);
    logic [15:0] w;
    logic [15:0] h;
    logic [23:0] sc;
    case (ph)
      1: begin
        w = 16'd640;
        h = 16'd480;
        sc = 24'd65536;
      end
      2: begin
        w = 16'd1;
        h = 16'd1;
        sc = '0;
      end
      3: begin
        w = 16'hFFFF;
        h = 16'hFFFF;
        sc = 24'hFF_FFFF;
      end
      4: begin
        w = '0;
        h = '0;
        sc = 24'($urandom());
      end
      default: begin
        w = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 2000)
                                            : $urandom_range(1, 65535));
        h = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 2000)
                                            : $urandom_range(1, 65535));
        sc = 24'($urandom_range(0, 262143));
      end
    endcase
    s_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    write_reg(beswb_pkg::CfgAreaWidth, {8'($urandom()), w});
    write_reg(beswb_pkg::CfgAreaHeight, {8'($urandom()), h});
    write_reg(beswb_pkg::CfgWorldScale, sc);
    if (ph == 1) begin
      write_reg(CfgSpare, 24'($urandom()));
    end
    cfg_we <= 1'b0;
    cur_w = 32'(w);
    cur_h = 32'(h);
    src_gaps  = (ph % 2 == 0);
    sink_gaps = (ph % 4 < 2);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < DirectedItems; k++) begin
      push_body(directed_body(k));
    end
    for (int ph = 1; ph <= Phases; ph++) begin
      configure(ph);
      if (ph == HoldPhase) begin
        hold_sink = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        push_body(random_body());
      end
    end
    s_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : sink
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        gap = sink_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
          m_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
